// ===== rtl/column_abs_diff_sum_assert.svh =====
// Assertion macros shared by the column SAD design files.
// Included by modules that check their own logic; no other dependencies.
`ifndef COLUMN_ABS_DIFF_SUM_ASSERT_SVH
`define COLUMN_ABS_DIFF_SUM_ASSERT_SVH
`ifndef SYNTHESIS
`define CAD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("column_abs_diff_sum assertion failed");
`define CAD_ASSERT_NEVER(label, expr) \
  `CAD_ASSERT(label, !(expr))
`else
`define CAD_ASSERT(label, prop)
`define CAD_ASSERT_NEVER(label, expr)
`endif
`endif

// ===== rtl/cad_pkg.sv =====
// Shared types and constants of the column sum-of-absolute-differences block.
// No dependencies; imported by every module of the design but cad_ram.
package cad_pkg;

  localparam int COLUMNS     = 32;
  localparam int ROWS        = 32;
  localparam int ColW        = $clog2(COLUMNS);
  localparam int RowW        = $clog2(ROWS);
  localparam int SampleW     = 12;
  localparam int SumW        = 17;
  localparam int IdxW        = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QueueAw     = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [SampleW-1:0] current_sample;
    logic [SampleW-1:0] previous_sample;
  } cad_in_t;

  typedef struct packed {
    logic [IdxW-1:0] column_index;
    logic [SumW-1:0] column_sum;
    logic            last_column;
  } cad_out_t;

  // One classified cell on its way from the front part to the back part.
  typedef struct packed {
    logic [ColW-1:0]    col;
    logic [SampleW-1:0] diff;
    logic               first_row;
    logic               last_cell;
  } cad_entry_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_DRAIN
  } cad_state_e;

endpackage

// ===== rtl/cad_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
module cad_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cad_front.sv =====
// Front part: takes cells, tracks the row/column position and forms |cur - prev|.
// Depends on cad_pkg.
module cad_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  cad_pkg::cad_in_t    sample_i,
  input  logic                full_i,
  output logic                busy,
  output logic                push_o,
  output cad_pkg::cad_entry_t entry_o
);
  import cad_pkg::*;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            col_end, row_end;

  assign busy    = full_i;
  assign push_o  = start && !full_i;
  assign col_end = (col_q == ColW'(COLUMNS - 1));
  assign row_end = (row_q == RowW'(ROWS - 1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_comb begin
    entry_o.col       = col_q;
    entry_o.first_row = (row_q == '0);
    entry_o.last_cell = row_end && col_end;
    if (sample_i.current_sample >= sample_i.previous_sample) begin
      entry_o.diff = sample_i.current_sample - sample_i.previous_sample;
    end else begin
      entry_o.diff = sample_i.previous_sample - sample_i.current_sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== rtl/cad_fifo.sv =====
// Short queue of classified cells between the front and back parts.
// Depends on cad_pkg and the assertion macro header.
`include "column_abs_diff_sum_assert.svh"
module cad_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cad_pkg::cad_entry_t entry_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output cad_pkg::cad_entry_t entry_o
);
  import cad_pkg::*;

  cad_entry_t         slot_q [QUEUE_DEPTH];
  logic [QueueAw-1:0] wptr_q, rptr_q;
  logic [QueueAw:0]   count_q, count_d;

  assign full_o  = (count_q == (QueueAw + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QueueAw + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QueueAw + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QueueAw'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QueueAw'(1);
      end
      count_q <= count_d;
    end
  end

  `CAD_ASSERT_NEVER(fifo_no_overflow, push_i && full_o)
  `CAD_ASSERT_NEVER(fifo_no_underflow, pop_i && !valid_o)

endmodule

// ===== rtl/cad_back.sv =====
// Back part: accumulates differences per column in a RAM and drains the sums.
// Depends on cad_pkg, cad_ram and the assertion macro header.
`include "column_abs_diff_sum_assert.svh"
module cad_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  cad_pkg::cad_entry_t q_entry_i,
  output logic                q_pop_o,
  output logic                result_valid_o,
  output cad_pkg::cad_out_t   result_o
);
  import cad_pkg::*;

  cad_state_e      state_q, state_d;
  logic [ColW-1:0] drain_cnt_q, drain_cnt_d;
  logic            s1_valid_q;
  cad_entry_t      s1_entry_q;
  logic            res_valid_q;
  logic [ColW-1:0] res_idx_q;
  logic            res_last_q;

  logic            ram_re, ram_we;
  logic [ColW-1:0] ram_raddr;
  logic [SumW-1:0] ram_wdata, ram_rdata;
  logic [SumW:0]   sum_wide;
  logic            drain_end;

  assign drain_end = (drain_cnt_q == ColW'(COLUMNS - 1));

  always_comb begin
    state_d     = state_q;
    drain_cnt_d = drain_cnt_q;
    q_pop_o     = 1'b0;
    case (state_q)
      ST_ACCUM: begin
        q_pop_o = q_valid_i;
        if (q_valid_i && q_entry_i.last_cell) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // The last cell's write lands this cycle; reads start afterwards.
        state_d     = ST_DRAIN;
        drain_cnt_d = '0;
      end
      ST_DRAIN: begin
        drain_cnt_d = drain_cnt_q + ColW'(1);
        if (drain_end) begin
          state_d = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  assign ram_re    = q_pop_o || (state_q == ST_DRAIN);
  assign ram_raddr = (state_q == ST_DRAIN) ? drain_cnt_q : q_entry_i.col;
  assign ram_we    = s1_valid_q;
  assign sum_wide  = {1'b0, ram_rdata} + (SumW + 1)'(s1_entry_q.diff);

  always_comb begin
    if (s1_entry_q.first_row) begin
      ram_wdata = SumW'(s1_entry_q.diff);
    end else if (sum_wide[SumW]) begin
      ram_wdata = '1;
    end else begin
      ram_wdata = sum_wide[SumW-1:0];
    end
  end

  cad_ram #(
    .Width (SumW),
    .Depth (COLUMNS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_entry_q.col),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_entry_q <= q_entry_i;
    end
    res_idx_q  <= drain_cnt_q;
    res_last_q <= drain_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      drain_cnt_q <= '0;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      drain_cnt_q <= drain_cnt_d;
      s1_valid_q  <= q_pop_o;
      res_valid_q <= (state_q == ST_DRAIN);
    end
  end

  assign result_valid_o          = res_valid_q;
  assign result_o.column_index   = IdxW'(res_idx_q);
  assign result_o.column_sum     = ram_rdata;
  assign result_o.last_column    = res_last_q;

  `CAD_ASSERT(flush_then_drain, state_q == ST_FLUSH |=> state_q == ST_DRAIN)
  `CAD_ASSERT_NEVER(no_write_in_drain, ram_we && state_q == ST_DRAIN)
  `CAD_ASSERT(burst_ends, res_valid_q && res_last_q |=> !res_valid_q)

endmodule

// ===== rtl/column_abs_diff_sum.sv =====
// Column-wise sum of absolute differences between two sensor frames, one
// cell per transfer in row-major order. After the last cell of a frame the
// block sends one result per column, in column order, one per cycle, with
// last_column set on the final one; the receiver must take every result in
// the cycle it is shown. A cell is taken in every cycle in which start is
// high and busy is low. A four-entry queue sits between the cell counter and
// the accumulator RAM, so cells keep arriving at one per cycle while the
// previous frame drains: the drain occupies the RAM read port in the FLUSH and
// DRAIN states after the last cell, and busy rises only once the queue
// fills during that window. Depends on cad_pkg, cad_front, cad_fifo, cad_back.
module column_abs_diff_sum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cad_pkg::cad_in_t  sample_i,
  output logic              result_valid_o,
  output cad_pkg::cad_out_t result_o
);
  import cad_pkg::*;

  logic       push, pop, full, q_valid;
  cad_entry_t push_entry, head_entry;

  cad_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .sample_i (sample_i),
    .full_i   (full),
    .busy     (busy),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  cad_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  cad_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (head_entry),
    .q_pop_o        (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== bench/tb_column_abs_diff_sum.sv =====
// Self-checking bench for column_abs_diff_sum: full sensor frames in, column sums checked.
// Needs cad_pkg and the design under rtl/; a class inside predicts and checks the sums.
`timescale 1ns / 100ps

module tb_column_abs_diff_sum;
  import cad_pkg::*;

  localparam int FrameCells = ROWS * COLUMNS;
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = COLUMNS + 2 * QUEUE_DEPTH + 8;
  localparam int KindCount  = 5;
  localparam logic [SampleW-1:0] SampleMax = '1;
  localparam logic [SumW-1:0]    SumMax    = '1;

  typedef enum int {
    FRAME_UNIFORM,
    FRAME_MAX_DIFF,
    FRAME_EXTREMES,
    FRAME_EQUAL,
    FRAME_NEAR
  } frame_kind_e;

  // Predicts the column sums of each frame and checks the block's results in order.
  class ColumnSadTracker;
    logic [SumW-1:0] col_acc [COLUMNS];
    int              cell_pos;
    cad_out_t        sums_due [$];
    int              error_count;

    function new();
      cell_pos    = 0;
      error_count = 0;
      foreach (col_acc[i]) col_acc[i] = '0;
    endfunction

    function void add_cell(cad_in_t cell_data);
      logic [SampleW-1:0] diff;
      logic [SumW:0]      total;
      cad_out_t           res;
      int                 row;
      int                 col;
      diff = (cell_data.current_sample >= cell_data.previous_sample) ?
             cell_data.current_sample - cell_data.previous_sample :
             cell_data.previous_sample - cell_data.current_sample;
      row = cell_pos / COLUMNS;
      col = cell_pos % COLUMNS;
      // The first row loads the column; later rows add and saturate.
      if (row == 0) begin
        col_acc[col] = SumW'(diff);
      end else begin
        total = {1'b0, col_acc[col]} + (SumW + 1)'(diff);
        col_acc[col] = total[SumW] ? SumMax : total[SumW-1:0];
      end
      if (cell_pos + 1 < FrameCells) begin
        cell_pos++;
      end else begin
        cell_pos = 0;
        for (int k = 0; k < COLUMNS; k++) begin
          res.column_index = IdxW'(k);
          res.column_sum   = col_acc[k];
          res.last_column  = (k == COLUMNS - 1);
          sums_due.push_back(res);
        end
      end
    endfunction

    function void check_sum(cad_out_t got);
      cad_out_t want;
      if (sums_due.size() == 0) begin
        $error("column sum with none expected: index %0d sum %0d last %0b",
               got.column_index, got.column_sum, got.last_column);
        error_count++;
        return;
      end
      want = sums_due.pop_front();
      if (got.column_index !== want.column_index) begin
        $error("column_index: expected %0d, got %0d", want.column_index, got.column_index);
        error_count++;
      end
      if (got.column_sum !== want.column_sum) begin
        $error("column_sum: expected %0d, got %0d", want.column_sum, got.column_sum);
        error_count++;
      end
      if (got.last_column !== want.last_column) begin
        $error("last_column: expected %0b, got %0b", want.last_column, got.last_column);
        error_count++;
      end
    endfunction

    function int pending();
      return sums_due.size();
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  cad_in_t  sample_i;
  logic     result_valid_o;
  cad_out_t result_o;

  ColumnSadTracker sad_track;
  int              cycle_count = 0;
  int              burst_left;

  // Corner cells sent at the head of the first frame.
  logic [SampleW-1:0] corner_cur [16] = '{
    12'd0, 12'd4095, 12'd4095, 12'd0, 12'd2048, 12'd2047, 12'd1, 12'd0,
    12'd4094, 12'd4095, 12'hAAA, 12'h555, 12'd4095, 12'd1, 12'h800, 12'h7FF
  };
  logic [SampleW-1:0] corner_prev [16] = '{
    12'd0, 12'd4095, 12'd0, 12'd4095, 12'd2047, 12'd2048, 12'd0, 12'd1,
    12'd4095, 12'd4094, 12'h555, 12'hAAA, 12'd1, 12'd4095, 12'h7FF, 12'h800
  };

  column_abs_diff_sum uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_i       (sample_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Every transfer and every result is observed here, on the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sad_track.add_cell(sample_i);
      if (result_valid_o) sad_track.check_sum(result_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic cad_in_t make_cell(frame_kind_e kind);
    cad_in_t cell_data;
    int      base;
    int      other;
    case (kind)
      FRAME_MAX_DIFF: begin
        if ($urandom_range(0, 1)) begin
          cell_data.current_sample  = SampleMax;
          cell_data.previous_sample = '0;
        end else begin
          cell_data.current_sample  = '0;
          cell_data.previous_sample = SampleMax;
        end
      end
      FRAME_EXTREMES: begin
        cell_data.current_sample  = $urandom_range(0, 1) ? SampleMax : '0;
        cell_data.previous_sample = $urandom_range(0, 1) ? SampleMax : '0;
      end
      FRAME_EQUAL: begin
        cell_data.current_sample  = SampleW'($urandom_range(0, 4095));
        cell_data.previous_sample = cell_data.current_sample;
      end
      FRAME_NEAR: begin
        base  = $urandom_range(0, 4095);
        other = base + $urandom_range(0, 16) - 8;
        if (other < 0) other = 0;
        if (other > 4095) other = 4095;
        cell_data.current_sample  = SampleW'(base);
        cell_data.previous_sample = SampleW'(other);
      end
      default: begin
        cell_data.current_sample  = SampleW'($urandom_range(0, 4095));
        cell_data.previous_sample = SampleW'($urandom_range(0, 4095));
      end
    endcase
    return cell_data;
  endfunction

  // May hold start low for a while when the current burst is used up.
  task automatic maybe_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
  endtask

  // Presents one cell and returns on the edge that takes it.
  task automatic send_cell(cad_in_t cell_data);
    maybe_gap();
    start    <= 1'b1;
    sample_i <= cell_data;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_frame(frame_kind_e kind, int first_cell);
    for (int i = first_cell; i < FrameCells; i++) send_cell(make_cell(kind));
  endtask

  // Each row takes the next stimulus kind in turn, so one frame covers them all.
  task automatic send_mixed_frame(int first_cell);
    for (int i = first_cell; i < FrameCells; i++) begin
      send_cell(make_cell(frame_kind_e'((i / COLUMNS) % KindCount)));
    end
  endtask

  task automatic wait_all_sums();
    start <= 1'b0;
    // The last accepted cell reaches the scoreboard on this edge at the latest.
    @(posedge clk_i);
    while (sad_track.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    cad_in_t cell_data;
    sad_track   = new();
    burst_left  = 0;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    sample_i    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_cur[i]) begin
      cell_data.current_sample  = corner_cur[i];
      cell_data.previous_sample = corner_prev[i];
      send_cell(cell_data);
    end
    send_mixed_frame($size(corner_cur));
    wait_all_sums();
    // The largest column sum the default size allows: every cell at full difference.
    send_frame(FRAME_MAX_DIFF, 0);
    // Cells of the next frame arrive while the sums drain, so the queue fills up.
    for (int i = 0; i < 2 * COLUMNS; i++) send_cell(make_cell(FRAME_UNIFORM));

    wait_all_sums();
    repeat (DrainWait) @(posedge clk_i);
    if (sad_track.error_count == 0 && sad_track.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
